// File: design/dust_conserved_primitive_convert_core_assert.svh
// Assertion macros for the dust converter modules; included by the queue
`ifndef DUST_CONSERVED_PRIMITIVE_CONVERT_CORE_ASSERT_SVH
`define DUST_CONSERVED_PRIMITIVE_CONVERT_CORE_ASSERT_SVH
`ifndef SYNTH
`define DCPC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DCPC_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define DCPC_ASSERT(lbl, clk, rst, prop, msg)
`define DCPC_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

// File: design/dcpc_pkg.sv
// Shared types and constants of the dust conserved/primitive converter
package dcpc_pkg;
  localparam int DENS_W = 31;
  localparam int DATA_W = 32;
  localparam int NUM_W = 33;
  localparam int NCOMP = 3;
  localparam int MAX_SPECIES = 4;
  localparam int SP_W = 2;
  localparam int NUM_SPECIES_DEF = 4;
  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_IDX_W = 3;
  localparam int IN_TDATA_W = 224;
  localparam int IN_TUSER_W = 3;
  localparam int OUT_TDATA_W = 128;
  localparam int OUT_TUSER_W = 2;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FLOOR0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIFF_EN = 3'd4;

  localparam logic OP_C2P = 1'b0;
  localparam logic OP_P2C = 1'b1;

  // One classified cell handed from front to back
  typedef struct packed {
    logic                          op;
    logic [DENS_W-1:0]             dens;
    logic [NCOMP-1:0][NUM_W-1:0]   num;
    logic [NCOMP-1:0][DATA_W-1:0]  add;
    logic                          fa;
    logic                          last;
  } item_t;
endpackage

// File: design/dcpc_front.sv
// Front end: accept a cell, apply the floor and the diffusion term, classify
module dcpc_front import dcpc_pkg::*; #(
  parameter int NUM_SPECIES = NUM_SPECIES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   opcode,
  input  logic [SP_W-1:0]        species,
  input  logic [DENS_W-1:0]      in_density,
  input  logic [NCOMP-1:0][DATA_W-1:0] in_comp,
  input  logic [NCOMP-1:0][DATA_W-1:0] diffusion,
  input  logic                   last_cell,
  input  logic [DENS_W-1:0]      floor_q [NUM_SPECIES],
  input  logic                   diff_en,
  output logic                   item_valid,
  input  logic                   item_ready,
  output item_t                  item
);
  logic                          f_vld;
  logic                          f_op;
  logic [SP_W-1:0]               f_sp;
  logic [DENS_W-1:0]             f_dens;
  logic [NCOMP-1:0][DATA_W-1:0]  f_comp;
  logic [NCOMP-1:0][DATA_W-1:0]  f_diff;
  logic                          f_last;
  logic [SP_W-1:0]               sp_c;
  logic [DENS_W-1:0]             fl;
  logic [DENS_W-1:0]             fl_eff;
  logic                          below;
  logic [NUM_W-1:0]              cx;
  logic [NUM_W-1:0]              dx;

  assign in_ready = !f_vld || item_ready;
  assign item_valid = f_vld;

  // Hold the accepted cell until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (in_ready) begin
      f_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      f_op   <= opcode;
      f_sp   <= species;
      f_dens <= in_density;
      f_comp <= in_comp;
      f_diff <= diffusion;
      f_last <= last_cell;
    end
  end

  // Select the species floor; a zero floor acts as one LSB
  always_comb begin
    sp_c = (32'(f_sp) >= NUM_SPECIES) ? SP_W'(NUM_SPECIES - 1) : f_sp;
    fl = '0;
    for (int i = 0; i < NUM_SPECIES; i++) begin
      if (32'(sp_c) == i) fl = floor_q[i];
    end
    fl_eff = (fl == '0) ? DENS_W'(1) : fl;
    below = f_dens < fl_eff;
  end

  // Build the queue entry
  always_comb begin
    item.op   = f_op;
    item.last = f_last;
    item.dens = f_dens;
    item.fa   = 1'b0;
    item.num  = '0;
    item.add  = '0;
    cx = '0;
    dx = '0;
    if (f_op == OP_C2P) begin
      if (below) begin
        item.dens = fl_eff;
        item.fa   = 1'b1;
      end
    end
    for (int c = 0; c < NCOMP; c++) begin
      cx = {f_comp[c][DATA_W-1], f_comp[c]};
      dx = diff_en ? {f_diff[c][DATA_W-1], f_diff[c]} : '0;
      if (f_op == OP_C2P) begin
        item.num[c] = cx - dx;
      end else begin
        item.num[c] = cx;
        item.add[c] = dx[DATA_W-1:0];
      end
    end
  end
endmodule

// File: design/dcpc_queue.sv
// Two-entry queue between front and back
module dcpc_queue import dcpc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t wr_item,
  output logic  full,
  input  logic  pop,
  output item_t rd_item,
  output logic  empty
);
  `include "dust_conserved_primitive_convert_core_assert.svh"

  item_t              mem [QDEPTH];
  logic [QPTR_W-1:0]  wptr;
  logic [QPTR_W-1:0]  rptr;
  logic [QCNT_W-1:0]  count;

  assign full    = count == QCNT_W'(QDEPTH);
  assign empty   = count == '0;
  assign rd_item = mem[rptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wr_item;
  end

  `DCPC_NEVER(a_no_overflow, clk, rst, push && full, "push into full queue")
  `DCPC_NEVER(a_no_underflow, clk, rst, pop && empty, "pop from empty queue")
  `DCPC_ASSERT(a_count_up, clk, rst, push && !pop |=> count == $past(count) + 1'b1, "count lost a push")
endmodule

// File: design/dcpc_back.sv
// Back end: pipelined restoring divider and multiply path, output register
module dcpc_back import dcpc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  output logic                          q_pop,
  input  item_t                         q_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [DENS_W-1:0]             out_density,
  output logic [NCOMP-1:0][DATA_W-1:0]  out_comp,
  output logic                          floor_applied,
  output logic                          saturated,
  output logic                          last_out
);
  localparam int NW = DATA_W + FRAC_BITS + 1;
  localparam int NST = DATA_W;

  logic en;

  // Stage data along the divider
  logic                           vld  [NST+1];
  logic                           op   [NST+1];
  logic [DENS_W-1:0]              dens [NST+1];
  logic                           fa   [NST+1];
  logic                           lst  [NST+1];
  logic [NCOMP-1:0][DENS_W-1:0]   rem  [NST+1];
  logic [NCOMP-1:0][DATA_W-1:0]   nlow [NST+1];
  logic [NCOMP-1:0][DATA_W-1:0]   quo  [NST+1];
  logic [NCOMP-1:0]               ngv  [NST+1];
  logic [NCOMP-1:0]               ovf  [NST+1];

  // Multiply path registers
  logic signed [2*DATA_W-1:0]     prod  [NCOMP];
  logic [NCOMP-1:0][DATA_W-1:0]   add0;
  logic signed [2*DATA_W-1:0]     exact [NCOMP];
  logic [2*DATA_W-1:0]            pmag  [NCOMP];
  logic [NCOMP-1:0]               pneg;
  logic [NCOMP-1:0][DATA_W-1:0]   mres  [3:NST];
  logic                           mclip [3:NST];

  logic [NW-1:0]                  nfull [NCOMP];
  logic [DATA_W-1:0]              mg    [NCOMP];
  logic signed [NUM_W-1:0]        sn    [NCOMP];
  logic [DATA_W:0]                rem2  [NST][NCOMP];
  logic                           ge    [NST][NCOMP];
  logic [2*DATA_W-1:0]            rnd   [NCOMP];
  logic [NCOMP-1:0][DATA_W-1:0]   mval;
  logic [NCOMP-1:0]               mcl;
  logic [NCOMP-1:0][DATA_W-1:0]   dval;
  logic [NCOMP-1:0]               dcl;

  assign en    = !out_valid || out_ready;
  assign q_pop = en && !q_empty;

  // Stage 0 setup: magnitude, scaled dividend, overflow check
  always_comb begin
    for (int c = 0; c < NCOMP; c++) begin
      sn[c] = $signed(q_item.num[c]);
      mg[c] = sn[c][NUM_W-1] ? DATA_W'(-sn[c]) : DATA_W'(sn[c]);
      nfull[c] = {1'b0, mg[c], FRAC_BITS'(0)} + NW'(q_item.dens >> 1);
    end
  end

  // Advance the valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= NST; j++) vld[j] <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld[0] <= q_pop;
      for (int j = 1; j <= NST; j++) vld[j] <= vld[j-1];
      out_valid <= vld[NST];
    end
  end

  // One quotient bit per stage
  always_comb begin
    for (int j = 0; j < NST; j++) begin
      for (int c = 0; c < NCOMP; c++) begin
        rem2[j][c] = {rem[j][c], nlow[j][c][DATA_W-1]};
        ge[j][c]   = rem2[j][c] >= {2'b0, dens[j]};
      end
    end
  end

  // Load stage 0 and advance the divider stages
  always_ff @(posedge clk) begin
    if (en) begin
      op[0]   <= q_item.op;
      dens[0] <= q_item.dens;
      fa[0]   <= q_item.fa;
      lst[0]  <= q_item.last;
      for (int c = 0; c < NCOMP; c++) begin
        ngv[0][c]  <= sn[c][NUM_W-1];
        ovf[0][c]  <= DENS_W'(nfull[c][NW-1:DATA_W]) >= q_item.dens;
        rem[0][c]  <= DENS_W'(nfull[c][NW-1:DATA_W]);
        nlow[0][c] <= nfull[c][DATA_W-1:0];
        quo[0][c]  <= '0;
        prod[c]    <= $signed(q_item.num[c][DATA_W-1:0]) * $signed({1'b0, q_item.dens});
        add0[c]    <= q_item.add[c];
      end
      for (int j = 1; j <= NST; j++) begin
        op[j]   <= op[j-1];
        dens[j] <= dens[j-1];
        fa[j]   <= fa[j-1];
        lst[j]  <= lst[j-1];
        ngv[j]  <= ngv[j-1];
        ovf[j]  <= ovf[j-1];
        for (int c = 0; c < NCOMP; c++) begin
          rem[j][c]  <= ge[j-1][c] ? DENS_W'(rem2[j-1][c] - {2'b0, dens[j-1]})
                                   : DENS_W'(rem2[j-1][c]);
          nlow[j][c] <= {nlow[j-1][c][DATA_W-2:0], 1'b0};
          quo[j][c]  <= {quo[j-1][c][DATA_W-2:0], ge[j-1][c]};
        end
      end
    end
  end

  // Multiply path: add diffusion, take magnitude, round and clip
  always_comb begin
    for (int c = 0; c < NCOMP; c++) begin
      rnd[c] = (pmag[c] + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      if (pneg[c]) begin
        mcl[c]  = rnd[c] > 64'h0000_0000_8000_0000;
        mval[c] = mcl[c] ? 32'h8000_0000 : DATA_W'(-rnd[c]);
      end else begin
        mcl[c]  = |rnd[c][2*DATA_W-1:DATA_W-1];
        mval[c] = mcl[c] ? 32'h7FFF_FFFF : rnd[c][DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < NCOMP; c++) begin
        exact[c] <= prod[c] + $signed({{(DATA_W-FRAC_BITS){add0[c][DATA_W-1]}}, add0[c],
                                       FRAC_BITS'(0)});
        pmag[c]  <= exact[c][2*DATA_W-1] ? 64'(-exact[c]) : 64'(exact[c]);
        pneg[c]  <= exact[c][2*DATA_W-1];
      end
      mres[3]  <= mval;
      mclip[3] <= |mcl;
      for (int j = 4; j <= NST; j++) begin
        mres[j]  <= mres[j-1];
        mclip[j] <= mclip[j-1];
      end
    end
  end

  // Divider result: apply sign and clip
  always_comb begin
    for (int c = 0; c < NCOMP; c++) begin
      if (ngv[NST][c]) begin
        dcl[c]  = ovf[NST][c] || (quo[NST][c] > 32'h8000_0000);
        dval[c] = dcl[c] ? 32'h8000_0000 : -quo[NST][c];
      end else begin
        dcl[c]  = ovf[NST][c] || quo[NST][c][DATA_W-1];
        dval[c] = dcl[c] ? 32'h7FFF_FFFF : quo[NST][c];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en) begin
      out_density   <= dens[NST];
      floor_applied <= fa[NST];
      last_out      <= lst[NST];
      if (op[NST] == OP_C2P) begin
        out_comp  <= dval;
        saturated <= |dcl;
      end else begin
        out_comp  <= mres[NST];
        saturated <= mclip[NST];
      end
    end
  end
endmodule

// File: design/dust_conserved_primitive_convert_core.sv
// Top level of the dust conserved/primitive converter
//
// Use: each s_ transaction carries one grid cell of one dust species.
// s_tuser selects the direction (opcode) and the species; s_tlast marks the
// final cell of a sweep and comes back on m_tlast. Conserved to primitive
// floors the density and divides the momenta by it; primitive to conserved
// multiplies velocities by the density. Diffusion correction and the
// per-species floors are set through the cfg_ channel while idle; the user
// must see to this, the block does not enforce it. Throughput: one cell per
// cycle unless m_tready stalls it. A cell passes the front register, queue,
// setup, the 32-stage restoring divider (one quotient bit per stage) and the
// output register. Reset clears all valid state and loads floors of one LSB,
// diffusion off. The back pipeline holds with m_tvalid high, m_tready low;
// the two-entry queue and front register absorb items until s_tready drops.
module dust_conserved_primitive_convert_core import dcpc_pkg::*; #(
  parameter int NUM_SPECIES = NUM_SPECIES_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // in_density, in_comp_x, in_comp_y, in_comp_z, diffusion_x, diffusion_y,
  // diffusion_z, one zero pad bit
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // opcode, species
  input  logic [IN_TUSER_W-1:0]  s_tuser,
  input  logic                   s_tlast,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // out_density, out_comp_x, out_comp_y, out_comp_z, one zero pad bit
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // floor_applied, saturated
  output logic [OUT_TUSER_W-1:0] m_tuser,
  output logic                   m_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [DENS_W-1:0]      cfg_data
);
  logic [DENS_W-1:0]             floor_q [NUM_SPECIES];
  logic                          diff_en;
  logic [NCOMP-1:0][DATA_W-1:0]  in_comp;
  logic [NCOMP-1:0][DATA_W-1:0]  in_diff;
  logic                          f_valid;
  logic                          q_full;
  logic                          q_empty;
  logic                          q_pop;
  item_t                         f_item;
  item_t                         q_item;
  logic [DENS_W-1:0]             out_density;
  logic [NCOMP-1:0][DATA_W-1:0]  out_comp;
  logic                          floor_applied;
  logic                          saturated;

  assign cfg_ready = 1'b1;

  // Register file writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SPECIES; i++) floor_q[i] <= DENS_W'(1);
      diff_en <= 1'b0;
    end else if (cfg_valid) begin
      for (int i = 0; i < NUM_SPECIES; i++) begin
        if (cfg_index == REG_FLOOR0 + CFG_IDX_W'(i)) floor_q[i] <= cfg_data;
      end
      if (cfg_index == REG_DIFF_EN) diff_en <= cfg_data[0];
    end
  end

  // Unpack the input components
  always_comb begin
    for (int c = 0; c < NCOMP; c++) begin
      in_comp[c] = s_tdata[DENS_W + c*DATA_W +: DATA_W];
      in_diff[c] = s_tdata[DENS_W + (NCOMP + c)*DATA_W +: DATA_W];
    end
  end

  dcpc_front #(.NUM_SPECIES(NUM_SPECIES)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .opcode     (s_tuser[0]),
    .species    (s_tuser[2:1]),
    .in_density (s_tdata[DENS_W-1:0]),
    .in_comp    (in_comp),
    .diffusion  (in_diff),
    .last_cell  (s_tlast),
    .floor_q    (floor_q),
    .diff_en    (diff_en),
    .item_valid (f_valid),
    .item_ready (!q_full),
    .item       (f_item)
  );

  dcpc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (f_valid && !q_full),
    .wr_item (f_item),
    .full    (q_full),
    .pop     (q_pop),
    .rd_item (q_item),
    .empty   (q_empty)
  );

  dcpc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .q_item        (q_item),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_density   (out_density),
    .out_comp      (out_comp),
    .floor_applied (floor_applied),
    .saturated     (saturated),
    .last_out      (m_tlast)
  );

  assign m_tdata = {1'b0, out_comp[2], out_comp[1], out_comp[0], out_density};
  assign m_tuser = {saturated, floor_applied};
endmodule

// File: tb/sv/dcpc_scoreboard.sv
// Checker for the dust converter: predicts each cell result and compares it with the output
`timescale 1ns / 100ps
module dcpc_scoreboard import dcpc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic [IN_TUSER_W-1:0]  s_tuser,
  input  logic                   s_tlast,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic [OUT_TUSER_W-1:0] m_tuser,
  input  logic                   m_tlast,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [DENS_W-1:0]      cfg_data,
  output int                     errors,
  output int                     pending
);

  typedef struct {
    logic [DENS_W-1:0] dens;
    logic [DATA_W-1:0] comp [NCOMP];
    logic              floor_hit;
    logic              clipped;
    logic              last;
  } cell_result_t;

  logic [DENS_W-1:0] floor_reg [MAX_SPECIES];
  logic              diff_on;
  cell_result_t      expected_cells [$];

  assign pending = expected_cells.size();

  // Round-to-nearest quotient num * 2^16 / den, ties away from zero
  function automatic longint velocity_of(longint num, longint unsigned den);
    longint unsigned mag, q;
    mag = (num < 0) ? longint'(-num) : longint'(num);
    q = ((mag << FRAC_BITS_DEF) + (den >> 1)) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  // Round-to-nearest of value / 2^16, ties away from zero
  function automatic longint descale(longint v);
    longint unsigned mag, r;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    r = (mag + (64'd1 << (FRAC_BITS_DEF - 1))) >> FRAC_BITS_DEF;
    return (v < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic cell_result_t convert_cell(logic [IN_TDATA_W-1:0] d,
                                                logic [IN_TUSER_W-1:0] u, logic lst);
    cell_result_t     r;
    logic             op;
    logic [1:0]       sp;
    longint unsigned  dens, fl;
    longint           comp, diff, v;
    op = u[0];
    sp = u[2:1];
    dens = d[DENS_W-1:0];
    r.floor_hit = 1'b0;
    r.clipped = 1'b0;
    r.last = lst;
    if (op == OP_C2P) begin
      fl = floor_reg[sp];
      if (fl == 0) fl = 1;
      if (dens < fl) begin
        dens = fl;
        r.floor_hit = 1'b1;
      end
    end
    for (int i = 0; i < NCOMP; i++) begin
      comp = longint'($signed(d[DENS_W + DATA_W*i +: DATA_W]));
      diff = longint'($signed(d[DENS_W + DATA_W*(i+3) +: DATA_W]));
      if (op == OP_C2P)
        v = velocity_of(comp - (diff_on ? diff : 0), dens);
      else
        v = descale(comp * longint'(dens) + (diff_on ? diff * 65536 : 0));
      if (v > 64'sd2147483647) begin
        v = 64'sd2147483647;
        r.clipped = 1'b1;
      end else if (v < -64'sd2147483648) begin
        v = -64'sd2147483648;
        r.clipped = 1'b1;
      end
      r.comp[i] = v[DATA_W-1:0];
    end
    r.dens = dens[DENS_W-1:0];
    return r;
  endfunction

  // Track registers, queue predictions, compare outputs
  always @(posedge clk) begin
    cell_result_t e;
    int           n;
    n = 0;
    if (rst) begin
      for (int i = 0; i < MAX_SPECIES; i++) floor_reg[i] <= 31'd1;
      diff_on <= 1'b0;
      errors <= 0;
      expected_cells.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index < REG_DIFF_EN) floor_reg[cfg_index[1:0]] <= cfg_data;
        else if (cfg_index == REG_DIFF_EN) diff_on <= cfg_data[0];
      end
      if (s_tvalid && s_tready) expected_cells.push_back(convert_cell(s_tdata, s_tuser, s_tlast));
      if (m_tvalid && m_tready) begin
        if (expected_cells.size() == 0) begin
          $error("unexpected result transaction");
          n++;
        end else begin
          e = expected_cells.pop_front();
          if (m_tdata[DENS_W-1:0] !== e.dens) begin
            $error("out_density exp %h got %h", e.dens, m_tdata[DENS_W-1:0]);
            n++;
          end
          for (int i = 0; i < NCOMP; i++)
            if (m_tdata[DENS_W + DATA_W*i +: DATA_W] !== e.comp[i]) begin
              $error("out_comp[%0d] exp %h got %h", i, e.comp[i],
                     m_tdata[DENS_W + DATA_W*i +: DATA_W]);
              n++;
            end
          if (m_tuser[0] !== e.floor_hit) begin
            $error("floor_applied exp %b got %b", e.floor_hit, m_tuser[0]);
            n++;
          end
          if (m_tuser[1] !== e.clipped) begin
            $error("saturated exp %b got %b", e.clipped, m_tuser[1]);
            n++;
          end
          if (m_tlast !== e.last) begin
            $error("last_out exp %b got %b", e.last, m_tlast);
            n++;
          end
        end
      end
      errors <= errors + n;
    end
  end

endmodule

// File: tb/sv/tb_dust_conserved_primitive_convert_core.sv
// Testbench top for the dust converter: stimulus, configuration phases and verdict
`timescale 1ns / 100ps
module tb_dust_conserved_primitive_convert_core;
  import dcpc_pkg::*;

  localparam int DRAIN = 60;
  localparam longint LIMIT = 3000000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [IN_TUSER_W-1:0]  s_tuser = '0;
  logic                   s_tlast = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [OUT_TUSER_W-1:0] m_tuser;
  logic                   m_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [DENS_W-1:0]      cfg_data = '0;
  int                     errors, pending;
  int                     tx_idle_pct = 0, rx_idle_pct = 0;
  logic                   cell_taken = 1'b0, cfg_taken = 1'b0;
  longint                 cycles = 0;
  logic [DENS_W-1:0]      cur_floor [MAX_SPECIES];

  always #2 clk = ~clk;

  dust_conserved_primitive_convert_core dut (.*);
  dcpc_scoreboard u_check (.*);

  // Record handshakes at the edge for the driver to read at the next falling edge
  always @(posedge clk) begin
    cell_taken <= s_tvalid && s_tready;
    cfg_taken <= cfg_valid && cfg_ready;
  end

  // Stall the result side at random
  always @(negedge clk)
    m_tready = ($urandom_range(99) >= rx_idle_pct);

  // Abort on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DENS_W-1:0] val);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid = 1'b0;
    if (idx < REG_DIFF_EN) cur_floor[idx[1:0]] = val;
  endtask

  // Wait for every result, then let the pipeline empty
  task automatic drain();
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic send_cell(logic op, logic [1:0] sp, logic [DENS_W-1:0] dens,
                           logic [DATA_W-1:0] cx, cy, cz, dx, dy, dz, logic lst);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tdata = {1'b0, dz, dy, dx, cz, cy, cx, dens};
    s_tuser = {sp, op};
    s_tlast = lst;
    s_tvalid = 1'b1;
    do @(negedge clk); while (!cell_taken);
  endtask

  task automatic directed_cells();
    logic [DATA_W-1:0] mx, mn;
    mx = 32'h7fffffff;
    mn = 32'h80000000;
    send_cell(OP_C2P, 2'd0, 31'd0, 32'h10000, mn, mx, '0, '0, '0, 1'b0);
    send_cell(OP_C2P, 2'd1, DENS_W'(cur_floor[1] - 1), mx, mn, 32'hffff8000, mx, mn, 32'd1,
              1'b1);
    send_cell(OP_C2P, 2'd2, cur_floor[2], 32'h00018000, 32'hfffe8000, '0, mn, mx, 32'h8000,
              1'b0);
    send_cell(OP_C2P, 2'd3, 31'h7fffffff, mx, mn, 32'd1, 32'hffffffff, 32'd1, '0, 1'b1);
    send_cell(OP_C2P, 2'd3, 31'd1, mx, mn, 32'h8000, '0, '0, '0, 1'b0);
    send_cell(OP_P2C, 2'd0, 31'd0, mx, mn, 32'd1, mx, mn, 32'h10000, 1'b1);
    send_cell(OP_P2C, 2'd1, 31'h7fffffff, mx, mn, 32'hffffffff, mx, mn, '0, 1'b0);
    send_cell(OP_P2C, 2'd2, 31'h00010000, 32'h00028000, 32'hfffd8000, '0, 32'd1, 32'hffffffff,
              '0, 1'b1);
    send_cell(OP_P2C, 2'd3, 31'h00008000, 32'd1, 32'hffffffff, 32'd3, mn, mx, 32'h12345678,
              1'b0);
    send_cell(OP_P2C, 2'd0, 31'h00000001, 32'h00008000, 32'hffff8000, '0, '0, '0, '0, 1'b1);
    drain();
  endtask

  function automatic logic [DATA_W-1:0] rand_comp();
    case ($urandom_range(3))
      0: return $urandom_range(0, 32'h0003ffff) - 32'h00020000;
      1: return $urandom_range(1) ? 32'h7fffffff - $urandom_range(3)
                                  : 32'h80000000 + $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_cell();
    logic [1:0]        sp;
    logic [DENS_W-1:0] dens;
    sp = 2'($urandom_range(3));
    case ($urandom_range(4))
      0: dens = DENS_W'($urandom);
      1: dens = DENS_W'(cur_floor[sp] + $urandom_range(8) - 4);
      2: dens = DENS_W'($urandom_range(32'h00020000));
      3: dens = $urandom_range(1) ? 31'h7fffffff : 31'h0;
      default: dens = DENS_W'($urandom >> $urandom_range(31));
    endcase
    send_cell(1'($urandom_range(1)), sp, dens, rand_comp(), rand_comp(), rand_comp(),
              rand_comp(), rand_comp(), rand_comp(), 1'($urandom_range(1)));
  endtask

  initial begin
    for (int i = 0; i < MAX_SPECIES; i++) cur_floor[i] = 31'd1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed cells at the reset configuration, then with floors and diffusion
    directed_cells();
    write_reg(REG_FLOOR0, 31'h00010000);
    write_reg(CFG_IDX_W'(REG_FLOOR0 + 1), 31'h7fffffff);
    write_reg(CFG_IDX_W'(REG_FLOOR0 + 2), 31'h0);
    write_reg(CFG_IDX_W'(REG_FLOOR0 + 3), 31'h00000100);
    write_reg(REG_DIFF_EN, 31'h1);
    directed_cells();

    // Random phases; the idle pattern changes every two phases
    for (int ph = 0; ph < 6; ph++) begin
      for (int i = 0; i < MAX_SPECIES; i++)
        case ((ph + i) % 4)
          0: write_reg(CFG_IDX_W'(REG_FLOOR0 + i), 31'h7fffffff);
          1: write_reg(CFG_IDX_W'(REG_FLOOR0 + i), $urandom_range(1) ? 31'h0 : 31'h1);
          2: write_reg(CFG_IDX_W'(REG_FLOOR0 + i), DENS_W'($urandom_range(32'h00040000)));
          default: write_reg(CFG_IDX_W'(REG_FLOOR0 + i), DENS_W'($urandom));
        endcase
      write_reg(REG_DIFF_EN, DENS_W'({$urandom_range(32'h3fffffff), ph[0]}));
      write_reg(CFG_IDX_W'(REG_DIFF_EN + 1 + $urandom_range(2)), DENS_W'($urandom));
      case (ph / 2)
        0: begin tx_idle_pct = 24; rx_idle_pct = 88; end
        1: begin tx_idle_pct = 88; rx_idle_pct = 24; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      for (int n = 0; n < 255; n++) random_cell();
      drain();
    end

    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// File: dust_conserved_primitive_convert_core.f
+incdir+design
design/dcpc_pkg.sv
design/dcpc_front.sv
design/dcpc_queue.sv
design/dcpc_back.sv
design/dust_conserved_primitive_convert_core.sv
tb/sv/dcpc_scoreboard.sv
tb/sv/tb_dust_conserved_primitive_convert_core.sv
